// ===== rtl/tlw_pkg.sv =====
// Shared types, constants and the SGR attribute function of the terminal line writer.
package tlw_pkg;

    localparam int CHAR_W      = 21;
    localparam int COL_W       = 8;
    localparam int CELL_W      = 16;
    localparam int ATTR_W      = 16;
    localparam int PARAM_W     = 8;
    localparam int NCELL_W     = 4;
    localparam int NSCROLL_W   = 2;
    localparam int RESULT_W    = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;
    localparam int ESCAPE_FLAG_BIT = 13;

    localparam logic [COL_W-1:0]  LINE_WIDTH_RESET = 8'd100;
    localparam logic [ATTR_W-1:0] ATTR_RESET       = 16'h0007;
    localparam logic [ATTR_W-1:0] ESC_ATTR_MASK    = 16'hFF0F;
    localparam logic [CELL_W-1:0] SPACE_CHAR       = 16'h0020;

    localparam logic [CHAR_W-1:0] CH_TAB   = 21'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 21'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 21'h0D;
    localparam logic [CHAR_W-1:0] CH_ESC   = 21'h1B;
    localparam logic [CHAR_W-1:0] CH_SPC   = 21'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 21'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 21'h39;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 21'h3B;
    localparam logic [CHAR_W-1:0] CH_UA    = 21'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 21'h5A;
    localparam logic [CHAR_W-1:0] CH_LBRK  = 21'h5B;
    localparam logic [CHAR_W-1:0] CH_LA    = 21'h61;
    localparam logic [CHAR_W-1:0] CH_LM    = 21'h6D;
    localparam logic [CHAR_W-1:0] CH_LZ    = 21'h7A;
    localparam logic [CHAR_W-1:0] CH_WIDE  = 21'h010000;

    localparam logic KIND_CELL   = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // One queued command: a run of cell writes, then up to two scrolls.
    typedef struct packed {
        logic [NCELL_W-1:0]   ncell;
        logic [NSCROLL_W-1:0] nscroll;
        logic [COL_W-1:0]     col;
        logic [CELL_W-1:0]    ch;
        logic [ATTR_W-1:0]    attr;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [ATTR_W-1:0] apply_sgr(input logic [ATTR_W-1:0] a,
                                                    input logic [PARAM_W-1:0] p);
        logic [ATTR_W-1:0] r;
        logic [PARAM_W-1:0] d;
        r = a;
        d = '0;
        if (p == 8'd0) begin
            r = ATTR_RESET;
        end else if (p == 8'd1) begin
            r = a | 16'h0008;
        end else if (p == 8'd2) begin
            r = a | 16'h1000;
        end else if (p == 8'd3) begin
            r = a | 16'h0100;
        end else if (p == 8'd4) begin
            r = a | 16'h0200;
        end else if (p == 8'd5 || p == 8'd6) begin
            r = a | 16'h0400;
        end else if (p == 8'd9) begin
            r = a | 16'h0800;
        end else if (p == 8'd22) begin
            r = a & ~16'h1008;
        end else if (p == 8'd23) begin
            r = a & ~16'h0100;
        end else if (p == 8'd24) begin
            r = a & ~16'h0200;
        end else if (p == 8'd25) begin
            r = a & ~16'h0400;
        end else if (p == 8'd29) begin
            r = a & ~16'h0800;
        end else if (p >= 8'd30 && p <= 8'd37) begin
            d = p - 8'd30;
            r = (a & ~16'h0007) | {13'd0, d[2:0]};
        end else if (p == 8'd39) begin
            r = (a & ~16'h0007) | 16'h0007;
        end else if (p >= 8'd40 && p <= 8'd47) begin
            d = p - 8'd40;
            r = (a & ~16'h0070) | {9'd0, d[2:0], 4'd0};
        end else if (p == 8'd49) begin
            r = a & ~16'h0070;
        end
        return r;
    endfunction

endpackage

// ===== rtl/tlw_front.sv =====
// Front end: takes code points, runs the escape parser and cursor, issues commands.
module tlw_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tlw_pkg::COL_W-1:0]     cfg_wr_data,
    input  logic                          accept,
    input  logic [tlw_pkg::CHAR_W-1:0]    char_code,
    output logic                          push,
    output tlw_pkg::cmd_t                 cmd
);

    typedef enum logic [2:0] {
        PH_TEXT = 3'b001,
        PH_ESC  = 3'b010,
        PH_CSI  = 3'b100
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [tlw_pkg::COL_W-1:0]       width_reg;
    logic [tlw_pkg::COL_W-1:0]       cursor_reg, cursor_next;
    logic [tlw_pkg::ATTR_W-1:0]      cur_attr_reg, cur_attr_next;
    logic [tlw_pkg::ATTR_W-1:0]      pend_attr_reg, pend_attr_next;
    logic [tlw_pkg::PARAM_W-1:0]     param_reg, param_next;

    logic [tlw_pkg::COL_W-1:0]       cursor_mid;
    logic [tlw_pkg::COL_W-1:0]       tab_plus8;
    logic [tlw_pkg::COL_W-1:0]       tab_stop;
    logic [tlw_pkg::COL_W-1:0]       tab_span;
    logic [11:0]                     param_acc;
    logic                            lead_scroll;
    logic                            tail_scroll;
    logic                            is_letter;

    always_comb begin
        phase_next     = phase_reg;
        cursor_next    = cursor_reg;
        cur_attr_next  = cur_attr_reg;
        pend_attr_next = pend_attr_reg;
        param_next     = param_reg;
        cursor_mid     = cursor_reg;
        lead_scroll    = 1'b0;
        tail_scroll    = 1'b0;
        cmd.ncell      = '0;
        cmd.col        = cursor_reg;
        cmd.ch         = '0;
        cmd.attr       = cur_attr_reg;
        tab_plus8      = cursor_reg + 8'd8;
        tab_stop       = {tab_plus8[7:3], 3'b000};
        tab_span       = tab_stop - cursor_reg;
        param_acc      = {1'b0, param_reg, 3'b000} + {3'b000, param_reg, 1'b0}
                         + {8'd0, char_code[3:0]};
        is_letter      = (char_code >= tlw_pkg::CH_UA && char_code <= tlw_pkg::CH_UZ)
                         || (char_code >= tlw_pkg::CH_LA && char_code <= tlw_pkg::CH_LZ);

        case (phase_reg)
            PH_ESC: begin
                if (char_code == tlw_pkg::CH_LBRK) begin
                    phase_next     = PH_CSI;
                    param_next     = '0;
                    pend_attr_next = cur_attr_reg;
                end else begin
                    phase_next = PH_TEXT;
                end
            end
            PH_CSI: begin
                if (char_code >= tlw_pkg::CH_ZERO && char_code <= tlw_pkg::CH_NINE) begin
                    param_next = (param_acc > 12'd255) ? 8'd255 : param_acc[7:0];
                end else if (char_code == tlw_pkg::CH_SEMI) begin
                    pend_attr_next = tlw_pkg::apply_sgr(pend_attr_reg, param_reg);
                    param_next     = '0;
                end else if (is_letter) begin
                    if (char_code == tlw_pkg::CH_LM) begin
                        cur_attr_next = tlw_pkg::apply_sgr(pend_attr_reg, param_reg);
                    end
                    param_next = '0;
                    phase_next = PH_TEXT;
                end
            end
            default: begin
                if (char_code < tlw_pkg::CH_SPC) begin
                    if (char_code == tlw_pkg::CH_CR) begin
                        cursor_mid = '0;
                    end else if (char_code == tlw_pkg::CH_LF) begin
                        lead_scroll = 1'b1;
                        cursor_mid  = '0;
                    end else if (char_code == tlw_pkg::CH_TAB) begin
                        // fewer than sixteen columns left: scroll instead of blanks
                        if ({1'b0, cursor_reg} + 9'd16 > {1'b0, width_reg}) begin
                            lead_scroll = 1'b1;
                            cursor_mid  = '0;
                        end else begin
                            cmd.ncell  = tab_span[3:0];
                            cmd.ch     = tlw_pkg::SPACE_CHAR;
                            cursor_mid = tab_stop;
                        end
                    end else if (char_code == tlw_pkg::CH_ESC) begin
                        phase_next = PH_ESC;
                    end
                end else begin
                    cmd.ncell  = 4'd1;
                    cmd.ch     = char_code[15:0];
                    cursor_mid = cursor_reg + 8'd1;
                    if (char_code >= tlw_pkg::CH_WIDE) begin
                        cmd.attr = ((cur_attr_reg | 16'(1 << tlw_pkg::ESCAPE_FLAG_BIT))
                                    & tlw_pkg::ESC_ATTR_MASK)
                                   | {8'd0, char_code[19:16], 4'd0};
                    end
                end
                // wrap check after every character in normal text
                if (cursor_mid >= width_reg) begin
                    tail_scroll = 1'b1;
                    cursor_next = '0;
                end else begin
                    cursor_next = cursor_mid;
                end
            end
        endcase

        cmd.nscroll = {1'b0, lead_scroll} + {1'b0, tail_scroll};
        push        = accept && ((cmd.ncell != '0) || (cmd.nscroll != '0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TEXT;
            width_reg     <= tlw_pkg::LINE_WIDTH_RESET;
            cursor_reg    <= '0;
            cur_attr_reg  <= tlw_pkg::ATTR_RESET;
            pend_attr_reg <= tlw_pkg::ATTR_RESET;
            param_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                width_reg <= cfg_wr_data;
            end
            if (accept) begin
                phase_reg     <= phase_next;
                cursor_reg    <= cursor_next;
                cur_attr_reg  <= cur_attr_next;
                pend_attr_reg <= pend_attr_next;
                param_reg     <= param_next;
            end
        end
    end

endmodule

// ===== rtl/tlw_cmd_queue.sv =====
// Short command queue between the front end and the output sequencer.
module tlw_cmd_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  tlw_pkg::cmd_t         push_cmd,
    input  logic                  pop,
    output tlw_pkg::cmd_t         head_cmd,
    output tlw_pkg::queue_status_t status
);

    tlw_pkg::cmd_t                   entry_reg [tlw_pkg::QUEUE_DEPTH];
    logic [tlw_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [tlw_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [tlw_pkg::QUEUE_CW-1:0]    count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign status.full  = (count_reg == tlw_pkg::QUEUE_CW'(tlw_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 3'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/tlw_back.sv =====
// Back end: expands each command into cell writes and scrolls behind an output register.
module tlw_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tlw_pkg::cmd_t              head_cmd,
    input  tlw_pkg::queue_status_t     status,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [39:0]                m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    logic [tlw_pkg::RESULT_W-1:0]  sub_reg, sub_next;
    logic [tlw_pkg::RESULT_W-1:0]  total;
    logic                          load;
    logic                          take;
    logic                          is_last;
    logic                          is_cell;

    logic                          valid_reg;
    logic                          kind_reg;
    logic                          last_reg;
    logic [tlw_pkg::COL_W-1:0]     col_reg;
    logic [tlw_pkg::CELL_W-1:0]    ch_reg;
    logic [tlw_pkg::ATTR_W-1:0]    attr_reg;

    assign load    = !valid_reg || m_tready;
    assign take    = load && !status.empty;
    assign total   = head_cmd.ncell + {2'b00, head_cmd.nscroll};
    assign is_last = (sub_reg == total - 4'd1);
    assign is_cell = (sub_reg < head_cmd.ncell);
    assign pop     = take && is_last;

    always_comb begin
        sub_next = sub_reg;
        if (take) begin
            sub_next = is_last ? '0 : sub_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            kind_reg <= is_cell ? tlw_pkg::KIND_CELL : tlw_pkg::KIND_SCROLL;
            last_reg <= is_last;
            col_reg  <= is_cell ? head_cmd.col + {4'd0, sub_reg} : '0;
            ch_reg   <= is_cell ? head_cmd.ch : '0;
            attr_reg <= is_cell ? head_cmd.attr : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sub_reg   <= '0;
        end else begin
            if (load) begin
                valid_reg <= !status.empty;
            end
            sub_reg <= sub_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {attr_reg, ch_reg, col_reg};

endmodule

// ===== rtl/terminal_line_writer_sgr_core.sv =====
// Top level of the terminal line writer: front end, command queue and output sequencer.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tdata: char_code
//  m_       | out | m_tvalid/m_tready  | m_tdata: column, cell_char, cell_attr;
//           |     |                    | m_tuser: kind; m_tlast: last
//  cfg_     | in  | cfg_wr_en          | cfg_wr_data: line_width
//
// The front end takes one code point per cycle while the command queue has room.
// The output register delivers one result per cycle while m_tready is high, so a tab
// expands into up to eight cell writes and a line feed into up to two scrolls; the
// four-entry queue absorbs such bursts before s_tready drops.
// Reset (aresetn low, synchronous) empties the queue and the output register and
// restores cursor, attributes, parser and line width.
module terminal_line_writer_sgr_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [20:0] char_code, [23:21] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] column, [23:8] cell_char, [39:24] cell_attr
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast
);

    logic                    accept;
    logic                    push;
    logic                    pop;
    tlw_pkg::cmd_t           push_cmd;
    tlw_pkg::cmd_t           head_cmd;
    tlw_pkg::queue_status_t  status;

    assign s_tready = !status.full;
    assign accept   = s_tvalid && s_tready;

    tlw_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .char_code   (s_tdata[20:0]),
        .push        (push),
        .cmd         (push_cmd)
    );

    tlw_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (status)
    );

    tlw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .status   (status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/tlw_checker.sv =====
// Port-level checks of the terminal line writer, bound to its top level.
module tlw_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // an empty queue after reset takes input at once and shows no result
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("results or backpressure right after reset");

    // a scroll carries no column, character or attribute
    a_scroll_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 40'd0))
        else $error("scroll transaction with nonzero payload");

    // a scroll that is not the last result can only be followed by the closing scroll
    a_scroll_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tuser && !m_tlast) |=> (!m_tvalid || (m_tuser && m_tlast)))
        else $error("leading scroll not followed by the wrap scroll");

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind terminal_line_writer_sgr_core tlw_port_checker u_tlw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
